// ===== rtl/rrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_pkg
// shared widths, defaults and controller/datapath interface types for the
// round-robin schedule simulator
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int ARR_W     = 8;
  localparam int BUR_W     = 8;
  localparam int Q_W       = 8;
  localparam int IDX_OUT_W = 4;
  localparam int TAT_W     = 17;
  localparam int TOT_W     = 21;
  localparam int CLK_W     = 16;

  localparam logic [Q_W-1:0] QUANTUM_RST = 8'd2;

  typedef struct packed {
    logic in_ready;
    logic rd_cur;
    logic exec;
    logic tat;
    logic emit;
    logic rd_next;
    logic adv;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic fin;
    logic out_free;
    logic pend_zero;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/rrs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_if
// request channels of the round-robin schedule simulator: process load,
// completion result and quantum write
// ----------------------------------------------------------------------------
interface rrs_in_if;
  logic                      valid;
  logic                      ready;
  logic [rrs_pkg::ARR_W-1:0] arrival;
  logic [rrs_pkg::BUR_W-1:0] burst;
  logic                      last_process;

  modport source (output valid, arrival, burst, last_process, input ready);
  modport sink   (input valid, arrival, burst, last_process, output ready);
endinterface

interface rrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [rrs_pkg::IDX_OUT_W-1:0] process_index;
  logic signed [rrs_pkg::TAT_W-1:0] turnaround;
  logic signed [rrs_pkg::TAT_W-1:0] waiting;
  logic signed [rrs_pkg::TOT_W-1:0] total_turnaround;
  logic signed [rrs_pkg::TOT_W-1:0] total_waiting;
  logic                          last_result;

  modport source (output valid, process_index, turnaround, waiting, total_turnaround,
                  total_waiting, last_result, input ready);
  modport sink   (input valid, process_index, turnaround, waiting, total_turnaround,
                  total_waiting, last_result, output ready);
endinterface

interface rrs_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [rrs_pkg::Q_W-1:0] quantum;

  modport source (output valid, quantum, input ready);
  modport sink   (input valid, quantum, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_dp
// datapath: process stores, simulated clock, visit index, sums, quantum
// register and result output register
// ----------------------------------------------------------------------------
module rrs_dp #(
  parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  rrs_in_if.sink           in_ch,
  rrs_out_if.source        out_ch,
  rrs_cfg_if.sink          cfg_ch,
  input  rrs_pkg::cmd_t    cmd,
  output rrs_pkg::sts_t    sts
);
  import rrs_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  logic [ARR_W-1:0] arr_mem   [MAX_PROCS];
  logic [BUR_W-1:0] burst_mem [MAX_PROCS];
  logic [BUR_W-1:0] rem_mem   [MAX_PROCS];

  logic [Q_W-1:0]          quantum_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        pend_r;
  logic [CLK_W-1:0]        clk_r;
  logic [IDX_W-1:0]        vi_r;
  logic                    wip_r;
  logic signed [TOT_W-1:0] tsum_r;
  logic signed [TOT_W-1:0] wsum_r;
  logic [MAX_PROCS-1:0]    done_r;
  logic                    fin_r;

  logic [ARR_W-1:0]        arr_rd_r;
  logic [BUR_W-1:0]        bur_rd_r;
  logic [BUR_W-1:0]        rem_rd_r;
  logic signed [TAT_W-1:0] tat_r;
  logic signed [TAT_W-1:0] wt_r;

  logic                     out_valid_r;
  logic [IDX_OUT_W-1:0]     out_idx_r;
  logic signed [TAT_W-1:0]  out_tat_r;
  logic signed [TAT_W-1:0]  out_wt_r;
  logic signed [TOT_W-1:0]  out_ttot_r;
  logic signed [TOT_W-1:0]  out_wtot_r;
  logic                     out_last_r;

  logic                     load;
  logic                     room;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [IDX_W-1:0]         ld_addr;
  logic [CNT_W-1:0]         vi_inc;
  logic [IDX_W-1:0]         rd_addr;
  logic [Q_W-1:0]           q_eff;
  logic [BUR_W-1:0]         run;
  logic [BUR_W-1:0]         rem_new;
  logic                     cur_done;
  logic                     rem_we;
  logic [IDX_W-1:0]         rem_wa;
  logic [BUR_W-1:0]         rem_wd;
  logic [ARR_W:0]           ab_sum;
  logic signed [TOT_W-1:0]  tsum_nxt;
  logic signed [TOT_W-1:0]  wsum_nxt;
  logic                     pend_one;
  logic                     wrap;
  logic [31:0]              vi_ext;

  assign load     = in_ch.valid & cmd.in_ready;
  assign room     = cnt_r < CNT_MAX;
  assign cnt_nxt  = cnt_r + CNT_W'(room);
  assign ld_addr  = cnt_r[IDX_W-1:0];
  assign vi_inc   = CNT_W'(vi_r) + CNT_W'(1);
  assign rd_addr  = cmd.rd_next ? vi_inc[IDX_W-1:0] : vi_r;
  assign q_eff    = (quantum_r == '0) ? Q_W'(1) : quantum_r;
  assign run      = (rem_rd_r < q_eff) ? rem_rd_r : q_eff;
  assign rem_new  = rem_rd_r - run;
  assign cur_done = done_r[vi_r];
  assign rem_we   = (load & room) | (cmd.exec & ~cur_done);
  assign rem_wa   = cmd.exec ? vi_r : ld_addr;
  assign rem_wd   = cmd.exec ? rem_new : in_ch.burst;
  assign ab_sum   = {1'b0, arr_rd_r} + {1'b0, bur_rd_r};
  assign tsum_nxt = tsum_r + {{(TOT_W-TAT_W){tat_r[TAT_W-1]}}, tat_r};
  assign wsum_nxt = wsum_r + {{(TOT_W-TAT_W){wt_r[TAT_W-1]}}, wt_r};
  assign pend_one = pend_r == CNT_W'(1);
  assign wrap     = (vi_inc >= cnt_r) || ({{(CLK_W-ARR_W){1'b0}}, arr_rd_r} > clk_r);
  assign vi_ext   = 32'(vi_r);

  // process stores
  always_ff @(posedge clk) begin
    if (load && room) begin
      arr_mem[ld_addr]   <= in_ch.arrival;
      burst_mem[ld_addr] <= in_ch.burst;
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (cmd.rd_cur || cmd.rd_next) begin
      arr_rd_r <= arr_mem[rd_addr];
    end
    if (cmd.rd_cur) begin
      bur_rd_r <= burst_mem[vi_r];
      rem_rd_r <= rem_mem[vi_r];
    end
  end

  // simulation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= QUANTUM_RST;
      cnt_r       <= '0;
      pend_r      <= '0;
      clk_r       <= '0;
      vi_r        <= '0;
      wip_r       <= 1'b0;
      tsum_r      <= '0;
      wsum_r      <= '0;
      done_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        quantum_r <= cfg_ch.quantum;
      end
      if (load) begin
        if (room) begin
          cnt_r           <= cnt_nxt;
          done_r[ld_addr] <= 1'b0;
        end
        if (in_ch.last_process) begin
          pend_r <= cnt_nxt;
        end
      end
      if (cmd.exec) begin
        fin_r <= ~cur_done && (rem_new == '0);
        if (!cur_done) begin
          clk_r <= clk_r + CLK_W'(run);
          if (run != '0) begin
            wip_r <= 1'b1;
          end
        end
      end
      if (cmd.emit) begin
        done_r[vi_r] <= 1'b1;
        pend_r       <= pend_r - CNT_W'(1);
        wip_r        <= 1'b1;
        tsum_r       <= tsum_nxt;
        wsum_r       <= wsum_nxt;
      end
      if (cmd.adv && !cmd.clear) begin
        if (wrap) begin
          if (!wip_r) begin
            clk_r <= clk_r + CLK_W'(1);
          end
          wip_r <= 1'b0;
          vi_r  <= '0;
        end else begin
          vi_r <= vi_inc[IDX_W-1:0];
        end
      end
      if (cmd.clear) begin
        cnt_r  <= '0;
        pend_r <= '0;
        clk_r  <= '0;
        vi_r   <= '0;
        wip_r  <= 1'b0;
        tsum_r <= '0;
        wsum_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // completion figures and output register
  always_ff @(posedge clk) begin
    if (cmd.tat) begin
      tat_r <= {1'b0, clk_r} - {{(TAT_W-ARR_W){1'b0}}, arr_rd_r};
      wt_r  <= {1'b0, clk_r} - {{(TAT_W-ARR_W-1){1'b0}}, ab_sum};
    end
    if (cmd.emit) begin
      out_idx_r  <= vi_ext[IDX_OUT_W-1:0];
      out_tat_r  <= tat_r;
      out_wt_r   <= wt_r;
      out_ttot_r <= pend_one ? tsum_nxt : '0;
      out_wtot_r <= pend_one ? wsum_nxt : '0;
      out_last_r <= pend_one;
    end
  end

  assign in_ch.ready             = cmd.in_ready;
  assign cfg_ch.ready            = 1'b1;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.process_index    = out_idx_r;
  assign out_ch.turnaround       = out_tat_r;
  assign out_ch.waiting          = out_wt_r;
  assign out_ch.total_turnaround = out_ttot_r;
  assign out_ch.total_waiting    = out_wtot_r;
  assign out_ch.last_result      = out_last_r;

  always_comb begin
    sts.in_valid  = in_ch.valid;
    sts.in_last   = in_ch.last_process;
    sts.fin       = fin_r;
    sts.out_free  = ~out_valid_r | out_ch.ready;
    sts.pend_zero = pend_r == '0;
  end

endmodule

`default_nettype wire

// ===== rtl/rrs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_ctrl
// controller: sequences loading and the visits of the round-robin walk
// ----------------------------------------------------------------------------
module rrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  rrs_pkg::sts_t sts,
  output rrs_pkg::cmd_t cmd
);
  import rrs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_EX   = 7'b0000100,
    S_TAT  = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_NXRD = 7'b0100000,
    S_ADV  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid && sts.in_last) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_EX;
      end
      S_EX: begin
        cmd.exec  = 1'b1;
        state_nxt = S_TAT;
      end
      S_TAT: begin
        if (sts.fin) begin
          cmd.tat   = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_ADV;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_NXRD;
        end
      end
      S_NXRD: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_ADV;
      end
      S_ADV: begin
        cmd.adv = 1'b1;
        if (sts.pend_zero) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/round_robin_schedule_sim_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_schedule_sim_unit
// round-robin scheduling simulator: loads (arrival, burst) requests, then
// walks the loaded set with the configured quantum and returns one result
// request per completed process in completion order
// ----------------------------------------------------------------------------
// A load request is taken while the controller is idle. The request flagged
// last_process starts the walk, during which no load is taken; the walk is
// one visit after another through the controller's sequence: a visit reads
// the stores, executes, and if it completes a process computes its figures
// and issues the result (waiting while an earlier result still waits on
// out_ch.ready), then reads the next entry and advances. Store reads go
// through memories with registered read data. After the last result the set
// clears and loading starts over; the quantum stays.
module round_robin_schedule_sim_unit #(
  parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rrs_in_if.sink    in_ch,
  rrs_out_if.source out_ch,
  rrs_cfg_if.sink   cfg_ch
);
  import rrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  rrs_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free) else $error("result issued over a waiting result");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid) else $error("issued result not presented");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !in_ch.ready) else $error("load open during the walk");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.in_ready, cmd.rd_cur, cmd.exec, cmd.tat, cmd.emit, cmd.adv}))
    else $error("conflicting controller commands");
`endif

endmodule

`default_nettype wire
